[hw/rtl/kt_pkg.sv]
package kt_pkg;

   // Fixed field widths of one item and one result
   localparam int unsigned KEY_WORD_W = 64;
   localparam int unsigned KEY_WORDS  = 4;
   localparam int unsigned KEY_W      = KEY_WORD_W * KEY_WORDS;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned ENTRY_W    = KEY_W + TIME_W;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned SLOT_W     = 6;
   localparam int unsigned REQ_DATA_W = ENTRY_W;
   localparam int unsigned RSP_DATA_W = STATUS_W + SLOT_W;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_REFRESHED = 2'd0,
      ST_ADDED     = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // One result as handed from the search engine to the output register
   typedef struct packed {
      status_type              status;
      logic [SLOT_W-1:0]       slot;
   } result_type;

   // Search engine states
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

endpackage

[hw/rtl/key_table_update_or_insert.sv]
// Channel  Dir  Ports                          Contents
// req      in   req_tvalid/tready/tdata[287:0] key_word0..3, expire_time
// rsp      out  rsp_tvalid/tready/tdata[7:0]   status, slot
//
// After an item is accepted, the engine compares its key against the entries
// in order (all valid entries, or those up to the matching one; at most
// TABLE_DEPTH): the entry RAM read port yields one key per cycle. One item is
// handled at a time; the next item is taken only after the result has moved
// into the output register.
// Reset empties the table at once (the fill count clears); no clearing pass.
// A stalled result holds in the output register; the engine waits behind it.
module key_table_update_or_insert #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // key_word0 [63:0], key_word1 [127:64], key_word2 [191:128],
   // key_word3 [255:192], expire_time [287:256]
   input  logic [kt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status [1:0], slot [7:2]
   output logic [kt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import kt_pkg::*;

   logic                  res_valid;
   logic                  res_ready;
   result_type            res;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   kt_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item_key   (req_tdata[KEY_W-1:0]),
      .item_time  (req_tdata[ENTRY_W-1:KEY_W]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // Take a new result when the output register is empty or draining
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (res_ready) begin
         rsp_tvalid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Hold the result payload until taken
   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_tdata_ff <= {res.slot, res.status};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[hw/rtl/kt_ram.sv]
module kt_ram #(
   parameter int unsigned WIDTH = 288,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/kt_engine.sv]
module kt_engine #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  logic [kt_pkg::KEY_W-1:0]      item_key,
   input  logic [kt_pkg::TIME_W-1:0]     item_time,
   output logic                          res_valid,
   input  logic                          res_ready,
   output kt_pkg::result_type            res
);
   import kt_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   // Entries are only ever added at the lowest free slot and never removed,
   // so the valid entries are exactly slots below the fill count.
   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rd_addr_ff, rd_addr_in;
   logic                cmp_pending_ff, cmp_pending_in;
   logic [AW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [KEY_W-1:0]    key_ff;
   logic [TIME_W-1:0]   time_ff;
   status_type          res_status_ff, res_status_in;
   logic [AW-1:0]       res_idx_ff, res_idx_in;

   logic                rd_en;
   logic                wr_en;
   logic [ENTRY_W-1:0]  rd_data;
   logic                key_match;
   logic [AW+SLOT_W-1:0] idx_ext;

   // Entry store: expiry time above the key
   kt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (res_idx_ff),
      .wr_data ({time_ff, key_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign key_match = cmp_pending_ff && (rd_data[KEY_W-1:0] == key_ff);

   // Walk the valid entries, then settle the outcome
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_addr_in     = rd_addr_ff;
      cmp_pending_in = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      res_status_in  = res_status_ff;
      res_idx_in     = res_idx_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      item_ready     = 1'b0;
      res_valid      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            item_ready = !reset;
            if (item_valid) begin
               rd_addr_in = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (key_match) begin
               res_status_in = ST_REFRESHED;
               res_idx_in    = cmp_idx_ff;
               state_in      = S_FINISH;
            end else if (rd_addr_ff == count_ff) begin
               if (count_ff == CW'(TABLE_DEPTH)) begin
                  res_status_in = ST_FULL;
                  res_idx_in    = '0;
               end else begin
                  res_status_in = ST_ADDED;
                  res_idx_in    = count_ff[AW-1:0];
               end
               state_in = S_FINISH;
            end else begin
               rd_en          = 1'b1;
               cmp_pending_in = 1'b1;
               cmp_idx_in     = rd_addr_ff[AW-1:0];
               rd_addr_in     = rd_addr_ff + 1'b1;
            end
         end
         S_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               wr_en = (res_status_ff != ST_FULL);
               if (res_status_ff == ST_ADDED) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         rd_addr_ff     <= '0;
         cmp_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         rd_addr_ff     <= rd_addr_in;
         cmp_pending_ff <= cmp_pending_in;
      end
   end

   // Item payload and outcome
   always_ff @(posedge clock) begin
      if (item_valid && item_ready) begin
         key_ff  <= item_key;
         time_ff <= item_time;
      end
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
   end

   // Slot field carries the index modulo 64
   assign idx_ext    = {{SLOT_W{1'b0}}, res_idx_ff};
   assign res.status = res_status_ff;
   assign res.slot   = idx_ext[SLOT_W-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.status == ST_FULL) |-> count_ff == CW'(TABLE_DEPTH))
      else $error("table full reported with free slots");

   a_add_bumps_count: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready && res.status == ST_ADDED)
      |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("insert did not advance fill count");

   a_read_valid_only: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> rd_addr_ff < count_ff)
      else $error("read of an entry that was never written");

endmodule
